// ===== rtl/sha_pkg.sv =====
// SHA-256 package: round constants, initial hash values and round functions.
// No dependencies.
package sha_pkg;

    localparam int unsigned NUM_ROUNDS = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== rtl/sha256_message_digest.sv =====
// SHA-256 digest engine top level: byte packing, padding, round unit, output.
// Depends on sha_pkg.
//
// One byte word is taken per cycle while the engine is idle. The 64th byte of
// a block starts compression on the single iterated round unit: 64 rounds,
// then a fold of the result into the chaining words, during which stall is
// high. An end word writes 0x80 in its own cycle, unless its byte fills the
// block, in which case 0x80 opens the next block; padding then runs one pad
// byte per cycle to the end of the block; when the length no longer fits,
// that block is compressed and a second pad block follows. The eight digest
// words then leave one per accepted output cycle.
module sha256_message_digest
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  msg_byte,
    input  logic        byte_present,
    input  logic        msg_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } state_t;

    state_t       state_reg;
    logic         pad_mode_reg;   // compression belongs to padding
    logic         owe_mark_reg;   // 0x80 goes into the next block
    logic         len_blk_reg;    // current pad block carries the length
    logic [31:0]  chain_reg [8];
    logic [31:0]  work_reg [8];
    logic [31:0]  sched_reg [16]; // message schedule window, word 0 oldest
    logic [63:0]  bit_total_reg;
    logic [5:0]   byte_pos_reg;
    logic [5:0]   round_reg;
    logic [2:0]   out_idx_reg;

    logic         in_acc;
    logic         out_acc;
    logic [7:0]   pad_byte;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  w_new;
    logic [3:0]   widx;
    logic [4:0]   bsh;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign digest_word = chain_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign digest_last = (out_idx_reg == 3'd7);

    // Pad byte: 0x80 is written on entry; here zeros, then length bytes in the last block
    always_comb
    begin
        if (!len_blk_reg || byte_pos_reg < LEN_POS)
        begin
            pad_byte = 8'h00;
        end
        else
        begin
            pad_byte = bit_total_reg[8'(63 - 8 * int'(byte_pos_reg[2:0])) -: 8];
        end
    end

    // Shared round unit; schedule word computed from the sliding window
    always_comb
    begin
        w_new = small_sig1(sched_reg[14]) + sched_reg[9] + small_sig0(sched_reg[1])
                + sched_reg[0];
        t1 = work_reg[7] + big_sig1(work_reg[4])
             + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
             + round_k(round_reg) + sched_reg[0];
        t2 = big_sig0(work_reg[0])
             + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                ^ (work_reg[1] & work_reg[2]));
    end

    assign widx = byte_pos_reg[5:2];
    assign bsh  = 5'(8 * (3 - int'(byte_pos_reg[1:0])));

    // Control, packing and data path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pad_mode_reg  <= 1'b0;
            owe_mark_reg  <= 1'b0;
            len_blk_reg   <= 1'b0;
            bit_total_reg <= '0;
            byte_pos_reg  <= '0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_h(3'(i));
                work_reg[i]  <= '0;
            end
            for (int i = 0; i < 16; i++)
                sched_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        logic [5:0]  pos;
                        logic [31:0] word;
                        logic        full;
                        logic        wr_word;
                        logic [4:0]  mark_sh;
                        pos     = byte_pos_reg;
                        word    = sched_reg[widx];
                        full    = 1'b0;
                        wr_word = byte_present;
                        // first byte of a word clears the rest of it
                        if (byte_present)
                        begin
                            if (pos[1:0] == 2'd0)
                                word = {msg_byte, 24'h0};
                            else
                                word = word | (32'(msg_byte) << bsh);
                            bit_total_reg <= bit_total_reg + 64'd8;
                            full = (pos == 6'd63);
                            pos  = pos + 6'd1;
                        end
                        mark_sh = 5'(8 * (3 - int'(pos[1:0])));
                        // 0x80 follows in the same block when there is room
                        if (msg_end && !full)
                        begin
                            if (pos[1:0] == 2'd0)
                                sched_reg[pos[5:2]] <= {PAD_BYTE, 24'h0};
                            else
                            begin
                                word    = word | (32'(PAD_BYTE) << mark_sh);
                                wr_word = 1'b1;
                            end
                        end
                        if (wr_word)
                            sched_reg[widx] <= word;
                        pad_mode_reg <= msg_end;
                        owe_mark_reg <= msg_end && full;
                        len_blk_reg  <= msg_end && !full && (pos < LEN_POS);
                        if (full)
                        begin
                            byte_pos_reg <= pos;
                            state_reg    <= ST_ROUND;
                            round_reg    <= '0;
                            for (int i = 0; i < 8; i++)
                                work_reg[i] <= chain_reg[i];
                        end
                        else if (msg_end)
                        begin
                            byte_pos_reg <= pos + 6'd1;
                            if (pos == 6'd63)
                            begin
                                state_reg <= ST_ROUND;
                                round_reg <= '0;
                                for (int i = 0; i < 8; i++)
                                    work_reg[i] <= chain_reg[i];
                            end
                            else
                            begin
                                state_reg <= ST_PAD;
                            end
                        end
                        else
                        begin
                            byte_pos_reg <= pos;
                        end
                    end
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                        sched_reg[i] <= sched_reg[i + 1];
                    sched_reg[15] <= w_new;
                    work_reg[7] <= work_reg[6];
                    work_reg[6] <= work_reg[5];
                    work_reg[5] <= work_reg[4];
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[3] <= work_reg[2];
                    work_reg[2] <= work_reg[1];
                    work_reg[1] <= work_reg[0];
                    work_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(NUM_ROUNDS - 1))
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    if (!pad_mode_reg)
                    begin
                        byte_pos_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                    else if (len_blk_reg)
                    begin
                        // final block done
                        byte_pos_reg <= '0;
                        state_reg    <= ST_OUT;
                    end
                    else if (owe_mark_reg)
                    begin
                        // 0x80 opens the length block
                        sched_reg[0] <= {PAD_BYTE, 24'h0};
                        byte_pos_reg <= 6'd1;
                        owe_mark_reg <= 1'b0;
                        len_blk_reg  <= 1'b1;
                        state_reg    <= ST_PAD;
                    end
                    else
                    begin
                        byte_pos_reg <= '0;
                        len_blk_reg  <= 1'b1;
                        state_reg    <= ST_PAD;
                    end
                end
                ST_PAD:
                begin
                    if (byte_pos_reg[1:0] == 2'd0)
                        sched_reg[widx] <= {pad_byte, 24'h0};
                    else
                        sched_reg[widx] <= sched_reg[widx] | (32'(pad_byte) << bsh);
                    byte_pos_reg <= byte_pos_reg + 6'd1;
                    if (byte_pos_reg == 6'd63)
                    begin
                        state_reg <= ST_ROUND;
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            work_reg[i] <= chain_reg[i];
                    end
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            state_reg     <= ST_IDLE;
                            pad_mode_reg  <= 1'b0;
                            len_blk_reg   <= 1'b0;
                            bit_total_reg <= '0;
                            byte_pos_reg  <= '0;
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= init_h(3'(i));
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Never take input and produce output in the same cycle
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_acc && out_valid))
        else $error("input accepted while digest pending");
    // Last word leaves with index seven
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && digest_last) |-> (word_index == 3'd7))
        else $error("digest_last on wrong index");
    // After the last word the block returns to idle
    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && digest_last) |=> (!out_valid && !in_stall))
        else $error("no return to idle after digest");
`endif

endmodule
